@@ sv/gpg_pkg.sv @@
// shared types and constants of the gradient pixel generator
`default_nettype none

package gpg_pkg;

	// field and register widths
	localparam int COORD_FIELD_BITS = 16;
	localparam int CHAN_BITS        = 8;
	localparam int OUT_CHANNELS     = 3;
	localparam int COLOR_BITS       = CHAN_BITS * OUT_CHANNELS;
	localparam int INV_BITS         = 48;
	localparam int INV_HALF         = INV_BITS / 2;
	localparam int RATIO_BITS       = 18;
	localparam int BLEND_BITS       = RATIO_BITS - 1;
	localparam int SCALE_SHIFT      = 32;
	localparam int CFG_INDEX_BITS   = 3;
	localparam int CFG_DATA_BITS    = INV_BITS;

	// q16 ratio limits
	localparam logic [RATIO_BITS-1:0] RATIO_ONE = 18'd65536;
	localparam logic [RATIO_BITS-1:0] RATIO_MAX = 18'd131072;

	// gradient modes
	localparam logic [1:0] MODE_LINEAR   = 2'd0;
	localparam logic [1:0] MODE_BILINEAR = 2'd1;
	localparam logic [1:0] MODE_RADIAL   = 2'd2;
	localparam logic [1:0] MODE_SOLID    = 2'd3;

	// register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_MODE         = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNELS     = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FORE_COLOR   = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BACK_COLOR   = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DELTA_X      = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DELTA_Y      = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_INV_SCALE    = 3'd6;
	localparam logic [CFG_INDEX_BITS-1:0] REG_OFFSET_RATIO = 3'd7;

	// reset values
	localparam logic [1:0]            RST_CHANNELS   = 2'd3;
	localparam logic [COLOR_BITS-1:0] RST_BACK_COLOR = 24'hFFFFFF;

	typedef enum logic [1:0] {
		KIND_FORE,
		KIND_BACK,
		KIND_BLEND
	} kind_t;

	typedef struct packed {
		logic signed [COORD_FIELD_BITS-1:0] pos_x;
		logic signed [COORD_FIELD_BITS-1:0] pos_y;
		logic                               row_end;
	} in_word_t;

	typedef struct packed {
		logic [CHAN_BITS-1:0] chan_zero;
		logic [CHAN_BITS-1:0] chan_one;
		logic [CHAN_BITS-1:0] chan_two;
		logic                 span_end;
	} out_word_t;

	typedef struct packed {
		logic [1:0]                         mode;
		logic [1:0]                         channel_count;
		logic [COLOR_BITS-1:0]              fore_color;
		logic [COLOR_BITS-1:0]              back_color;
		logic signed [COORD_FIELD_BITS-1:0] delta_x;
		logic signed [COORD_FIELD_BITS-1:0] delta_y;
		logic [INV_BITS-1:0]                inv_scale;
		logic [RATIO_BITS-1:0]              offset_ratio;
	} cfg_regs_t;

	typedef struct packed {
		logic                  neg;
		logic [RATIO_BITS-1:0] ratio;
		logic                  span_end;
	} ratio_word_t;

endpackage

`default_nettype wire

@@ sv/gradient_pixel_generator_top.sv @@
// top level of the gradient pixel generator: register file and the two pipeline halves
//
// gradient pixel generator: each input word is a pixel position relative to the
// gradient start point, each output word is that pixel's colour (three 8-bit
// channels plus the span end flag copied from the input). one word is taken and
// one word is given per clock when the output side keeps ready high; every word
// passes from acceptance to out_valid through the seven register stages: projection
// or squared radius multiply, sum and magnitude, four 40-bit partial products
// against inv_scale, two partial sums, final add with the q16 clamp at 2.0,
// pixel kind with the per-channel blend multiply, and the output register. every
// stage holds its word while the stage after it is full and stalled, so
// backpressure on out_ready loses and repeats nothing and empty stages keep
// filling. the ratio is floor(|s| * inv_scale / 2^32) with the sign of s, where s
// is delta_x*pos_x + delta_y*pos_y, or pos_x^2 + pos_y^2 in radial mode.
// configuration is written through the cfg channel (always ready, one register
// per word, indexes 0 to 7 in the order mode, channel count, foreground,
// background, delta x, delta y, inv_scale, offset ratio) and must only be
// changed while no pixel is in flight.
`default_nettype none

module gradient_pixel_generator_top #(
	parameter int COORD_BITS   = 16,
	parameter int NUM_CHANNELS = 3
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// pixel position words
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire gpg_pkg::in_word_t                     in_data,
	// colour words
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output gpg_pkg::out_word_t                         out_data,
	// register writes
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [gpg_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  wire logic [gpg_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

	// register file, always ready for a write
	gpg_pkg::cfg_regs_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode          <= gpg_pkg::MODE_LINEAR;
			cfg_q.channel_count <= gpg_pkg::RST_CHANNELS;
			cfg_q.fore_color    <= '0;
			cfg_q.back_color    <= gpg_pkg::RST_BACK_COLOR;
			cfg_q.delta_x       <= '0;
			cfg_q.delta_y       <= '0;
			cfg_q.inv_scale     <= '0;
			cfg_q.offset_ratio  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gpg_pkg::REG_MODE: begin
					cfg_q.mode <= cfg_data[1:0];
				end
				gpg_pkg::REG_CHANNELS: begin
					cfg_q.channel_count <= cfg_data[1:0];
				end
				gpg_pkg::REG_FORE_COLOR: begin
					cfg_q.fore_color <= cfg_data[gpg_pkg::COLOR_BITS-1:0];
				end
				gpg_pkg::REG_BACK_COLOR: begin
					cfg_q.back_color <= cfg_data[gpg_pkg::COLOR_BITS-1:0];
				end
				gpg_pkg::REG_DELTA_X: begin
					cfg_q.delta_x <= $signed(cfg_data[gpg_pkg::COORD_FIELD_BITS-1:0]);
				end
				gpg_pkg::REG_DELTA_Y: begin
					cfg_q.delta_y <= $signed(cfg_data[gpg_pkg::COORD_FIELD_BITS-1:0]);
				end
				gpg_pkg::REG_INV_SCALE: begin
					cfg_q.inv_scale <= cfg_data[gpg_pkg::INV_BITS-1:0];
				end
				gpg_pkg::REG_OFFSET_RATIO: begin
					cfg_q.offset_ratio <= cfg_data[gpg_pkg::RATIO_BITS-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// ratio words between the two halves
	logic                 ratio_valid, ratio_ready;
	gpg_pkg::ratio_word_t ratio_word;

	// stages 1 to 5: signed q16 ratio
	gpg_ratio #(
		.COORD_BITS (COORD_BITS)
	) u_ratio (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_data),
		.cfg       (cfg_q),
		.out_valid (ratio_valid),
		.out_ready (ratio_ready),
		.out_word  (ratio_word)
	);

	// stages 6 and 7: kind decision, blend and output register
	gpg_shade #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_shade (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ratio_valid),
		.in_ready  (ratio_ready),
		.in_word   (ratio_word),
		.cfg       (cfg_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_data)
	);

endmodule

`default_nettype wire

@@ sv/gpg_ratio.sv @@
// ratio pipeline: projection or squared radius, magnitude, scaling by inv_scale, clamp
`default_nettype none

module gpg_ratio #(
	parameter int COORD_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire gpg_pkg::in_word_t   in_word,
	input  wire gpg_pkg::cfg_regs_t  cfg,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output gpg_pkg::ratio_word_t     out_word
);

	localparam int PROD_BITS = 2 * COORD_BITS;
	localparam int SUM_BITS  = PROD_BITS + 1;
	localparam int MAG_BITS  = PROD_BITS;
	localparam int PP_BITS   = COORD_BITS + gpg_pkg::INV_HALF;
	localparam int PART_BITS = PP_BITS + gpg_pkg::INV_HALF + 1;
	localparam int FULL_BITS = PART_BITS + COORD_BITS;
	localparam int QUO_BITS  = FULL_BITS - gpg_pkg::SCALE_SHIFT;

	// stage valids and advance enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	always_comb begin
		en5 = !v_s5 || out_ready;
		en4 = !v_s4 || en5;
		en3 = !v_s3 || en4;
		en2 = !v_s2 || en3;
		en1 = !v_s1 || en2;
	end

	assign in_ready = en1;

	// stage 1 operands
	logic signed [COORD_BITS-1:0] px, py, dx, dy, op_a, op_b;
	assign px = $signed(COORD_BITS'($unsigned(in_word.pos_x)));
	assign py = $signed(COORD_BITS'($unsigned(in_word.pos_y)));
	assign dx = $signed(COORD_BITS'($unsigned(cfg.delta_x)));
	assign dy = $signed(COORD_BITS'($unsigned(cfg.delta_y)));
	assign op_a = (cfg.mode == gpg_pkg::MODE_RADIAL) ? px : dx;
	assign op_b = (cfg.mode == gpg_pkg::MODE_RADIAL) ? py : dy;

	logic signed [PROD_BITS-1:0] prod_a_d, prod_b_d, prod_a_s1, prod_b_s1;
	logic                        end_s1;
	assign prod_a_d = PROD_BITS'(op_a) * PROD_BITS'(px);
	assign prod_b_d = PROD_BITS'(op_b) * PROD_BITS'(py);

	// stage 2 sum and magnitude
	logic signed [SUM_BITS-1:0] sum_d;
	logic [SUM_BITS-1:0]        abs_d;
	logic [MAG_BITS-1:0]        mag_s2;
	logic                       neg_s2, end_s2;
	assign sum_d = SUM_BITS'(prod_a_s1) + SUM_BITS'(prod_b_s1);
	assign abs_d = sum_d[SUM_BITS-1] ? $unsigned(-sum_d) : $unsigned(sum_d);

	// stage 3 partial products
	logic [COORD_BITS-1:0]       mag_lo, mag_hi;
	logic [gpg_pkg::INV_HALF-1:0] inv_lo, inv_hi;
	logic [PP_BITS-1:0]          pp_ll_s3, pp_lh_s3, pp_hl_s3, pp_hh_s3;
	logic                        neg_s3, end_s3;
	assign mag_lo = mag_s2[COORD_BITS-1:0];
	assign mag_hi = mag_s2[MAG_BITS-1:COORD_BITS];
	assign inv_lo = cfg.inv_scale[gpg_pkg::INV_HALF-1:0];
	assign inv_hi = cfg.inv_scale[gpg_pkg::INV_BITS-1:gpg_pkg::INV_HALF];

	// stage 4 partial sums, both relative to their own low weight
	logic [PART_BITS-1:0] lo_s4, hi_s4;
	logic                 neg_s4, end_s4;

	// stage 5 full product, quotient and clamp
	logic [FULL_BITS-1:0]          full_d;
	logic [QUO_BITS-1:0]           quo_d;
	logic [gpg_pkg::RATIO_BITS-1:0] ratio_d;
	gpg_pkg::ratio_word_t          word_s5;
	assign full_d = FULL_BITS'(lo_s4) + (FULL_BITS'(hi_s4) << COORD_BITS);
	assign quo_d  = full_d[FULL_BITS-1:gpg_pkg::SCALE_SHIFT];
	assign ratio_d = (quo_d > QUO_BITS'(gpg_pkg::RATIO_MAX)) ? gpg_pkg::RATIO_MAX
		: quo_d[gpg_pkg::RATIO_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			prod_a_s1 <= prod_a_d;
			prod_b_s1 <= prod_b_d;
			end_s1    <= in_word.row_end;
		end
		if (en2) begin
			mag_s2 <= abs_d[MAG_BITS-1:0];
			neg_s2 <= sum_d[SUM_BITS-1];
			end_s2 <= end_s1;
		end
		if (en3) begin
			pp_ll_s3 <= PP_BITS'(mag_lo) * PP_BITS'(inv_lo);
			pp_lh_s3 <= PP_BITS'(mag_lo) * PP_BITS'(inv_hi);
			pp_hl_s3 <= PP_BITS'(mag_hi) * PP_BITS'(inv_lo);
			pp_hh_s3 <= PP_BITS'(mag_hi) * PP_BITS'(inv_hi);
			neg_s3   <= neg_s2;
			end_s3   <= end_s2;
		end
		if (en4) begin
			lo_s4  <= PART_BITS'(pp_ll_s3) + (PART_BITS'(pp_lh_s3) << gpg_pkg::INV_HALF);
			hi_s4  <= PART_BITS'(pp_hl_s3) + (PART_BITS'(pp_hh_s3) << gpg_pkg::INV_HALF);
			neg_s4 <= neg_s3;
			end_s4 <= end_s3;
		end
		if (en5) begin
			word_s5.ratio    <= ratio_d;
			word_s5.neg      <= neg_s4 && (ratio_d != '0);
			word_s5.span_end <= end_s4;
		end
	end

	assign out_valid = v_s5;
	assign out_word  = word_s5;

	a_ratio_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.ratio <= gpg_pkg::RATIO_MAX)
		else $error("ratio above clamp");

	a_neg_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.neg |-> out_word.ratio != '0)
		else $error("negative sign on zero ratio");

	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !out_ready |=> v_s5)
		else $error("stalled ratio word dropped");

endmodule

`default_nettype wire

@@ sv/gpg_shade.sv @@
// shading pipeline: pixel kind, per-channel blend product, final colour
`default_nettype none

module gpg_shade #(
	parameter int NUM_CHANNELS = 3
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire gpg_pkg::ratio_word_t in_word,
	input  wire gpg_pkg::cfg_regs_t   cfg,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output gpg_pkg::out_word_t        out_word
);

	localparam int PROD_BITS = gpg_pkg::CHAN_BITS + 1 + gpg_pkg::RATIO_BITS;
	localparam int FRAC_BITS = 16;

	logic v_s6, v_s7, en6, en7;
	assign en7 = !v_s7 || out_ready;
	assign en6 = !v_s6 || en7;
	assign in_ready = en6;

	gpg_pkg::kind_t kind;

	always_comb begin
		case (cfg.mode)
			gpg_pkg::MODE_LINEAR: begin
				if (in_word.neg) kind = gpg_pkg::KIND_FORE;
				else if (in_word.ratio > gpg_pkg::RATIO_ONE) kind = gpg_pkg::KIND_BACK;
				else kind = gpg_pkg::KIND_BLEND;
			end
			gpg_pkg::MODE_BILINEAR, gpg_pkg::MODE_RADIAL: begin
				if (in_word.ratio > gpg_pkg::RATIO_ONE) kind = gpg_pkg::KIND_BACK;
				else if (in_word.ratio < cfg.offset_ratio) kind = gpg_pkg::KIND_FORE;
				else kind = gpg_pkg::KIND_BLEND;
			end
			default: begin
				kind = gpg_pkg::KIND_BACK;
			end
		endcase
	end

	// fore + floor((back - fore) * r / 2^16) per channel
	logic [gpg_pkg::CHAN_BITS-1:0]    base_d [gpg_pkg::OUT_CHANNELS];
	logic signed [PROD_BITS-1:0]      prod_d [gpg_pkg::OUT_CHANNELS];
	logic [gpg_pkg::CHAN_BITS-1:0]    base_s6 [gpg_pkg::OUT_CHANNELS];
	logic signed [PROD_BITS-1:0]      prod_s6 [gpg_pkg::OUT_CHANNELS];
	logic                             end_s6;

	always_comb begin
		logic [gpg_pkg::CHAN_BITS-1:0]    fc, bc;
		logic signed [gpg_pkg::CHAN_BITS:0] diff;
		logic signed [gpg_pkg::RATIO_BITS-1:0] rs;
		logic                             ch_on;
		rs = $signed({1'b0, in_word.ratio[gpg_pkg::BLEND_BITS-1:0]});
		for (int b = 0; b < gpg_pkg::OUT_CHANNELS; b++) begin
			fc = cfg.fore_color[b*gpg_pkg::CHAN_BITS +: gpg_pkg::CHAN_BITS];
			bc = cfg.back_color[b*gpg_pkg::CHAN_BITS +: gpg_pkg::CHAN_BITS];
			diff = $signed({1'b0, bc}) - $signed({1'b0, fc});
			ch_on = (b < NUM_CHANNELS) && (2'(b) < cfg.channel_count);
			if (!ch_on) begin
				base_d[b] = '0;
				prod_d[b] = '0;
			end else if (kind == gpg_pkg::KIND_BACK) begin
				base_d[b] = bc;
				prod_d[b] = '0;
			end else if (kind == gpg_pkg::KIND_FORE) begin
				base_d[b] = fc;
				prod_d[b] = '0;
			end else begin
				base_d[b] = fc;
				prod_d[b] = PROD_BITS'(diff) * PROD_BITS'(rs);
			end
		end
	end

	logic [gpg_pkg::CHAN_BITS-1:0] chan_d [gpg_pkg::OUT_CHANNELS];
	gpg_pkg::out_word_t            word_s7;

	always_comb begin
		for (int b = 0; b < gpg_pkg::OUT_CHANNELS; b++) begin
			chan_d[b] = base_s6[b]
				+ prod_s6[b][FRAC_BITS +: gpg_pkg::CHAN_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en6) v_s6 <= in_valid;
			if (en7) v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			base_s6 <= base_d;
			prod_s6 <= prod_d;
			end_s6  <= in_word.span_end;
		end
		if (en7) begin
			word_s7.chan_zero <= chan_d[0];
			word_s7.chan_one  <= chan_d[1];
			word_s7.chan_two  <= chan_d[2];
			word_s7.span_end  <= end_s6;
		end
	end

	assign out_valid = v_s7;
	assign out_word  = word_s7;

	a_solid_back: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cfg.mode == gpg_pkg::MODE_SOLID && cfg.channel_count != '0
		|-> out_word.chan_zero == cfg.back_color[gpg_pkg::CHAN_BITS-1:0])
		else $error("solid mode pixel is not background");

	a_no_channels: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cfg.channel_count == '0
		|-> out_word.chan_zero == '0 && out_word.chan_one == '0 && out_word.chan_two == '0)
		else $error("colour on pixel with no channels");

	a_one_channel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cfg.channel_count == 2'd1
		|-> out_word.chan_one == '0 && out_word.chan_two == '0)
		else $error("unused channel not zero");

endmodule

`default_nettype wire

@@ tb/sv/gradient_pixel_generator_checker.sv @@
// checker of the gradient pixel generator: colour prediction and word compare
`default_nettype none

module gradient_pixel_generator_checker #(
	parameter int NUM_CHANNELS = 3
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	input  wire logic                               in_ready,
	input  wire gpg_pkg::in_word_t                  in_data,
	input  wire logic                               out_valid,
	input  wire logic                               out_ready,
	input  wire gpg_pkg::out_word_t                 out_data,
	input  wire logic                               cfg_valid,
	input  wire logic                               cfg_ready,
	input  wire logic [gpg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [gpg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output int                                      errors,
	output int                                      words_out,
	output int                                      words_left
);
	import gpg_pkg::*;

	localparam int FRAC_BITS = 16;

	cfg_regs_t regs;
	out_word_t colors_due[$];

	// colour of one pixel under the given register set
	function automatic out_word_t shade_pixel(input in_word_t pix, input cfg_regs_t r);
		longint px, py, dx, dy, sum, mag_in;
		logic [111:0] prod;
		logic [RATIO_BITS-1:0] ratio;
		logic neg;
		kind_t kind;
		logic [31:0] fw, gw, rw, mix;
		logic [CHAN_BITS-1:0] ch [OUT_CHANNELS];
		out_word_t res;
		px = longint'(pix.pos_x);
		py = longint'(pix.pos_y);
		dx = longint'(r.delta_x);
		dy = longint'(r.delta_y);
		if (r.mode == MODE_RADIAL) begin
			sum = px * px + py * py;
		end else begin
			sum = dx * px + dy * py;
		end
		mag_in = (sum < 0) ? -sum : sum;
		prod = {48'b0, mag_in} * {64'b0, r.inv_scale};
		prod = prod >> SCALE_SHIFT;
		ratio = (prod > 112'(RATIO_MAX)) ? RATIO_MAX : prod[RATIO_BITS-1:0];
		// a ratio truncated to zero carries no sign
		neg = (sum < 0) && (ratio != '0);
		if (r.mode == MODE_SOLID) begin
			kind = KIND_BACK;
		end else if (r.mode == MODE_LINEAR) begin
			if (neg) kind = KIND_FORE;
			else if (ratio > RATIO_ONE) kind = KIND_BACK;
			else kind = KIND_BLEND;
		end else begin
			if (ratio > RATIO_ONE) kind = KIND_BACK;
			else if (ratio < r.offset_ratio) kind = KIND_FORE;
			else kind = KIND_BLEND;
		end
		rw = 32'(ratio);
		for (int b = 0; b < OUT_CHANNELS; b++) begin
			fw = 32'(r.fore_color[CHAN_BITS*b +: CHAN_BITS]);
			gw = 32'(r.back_color[CHAN_BITS*b +: CHAN_BITS]);
			mix = (fw * (32'(RATIO_ONE) - rw) + gw * rw) >> FRAC_BITS;
			if (b >= int'(r.channel_count) || b >= NUM_CHANNELS) begin
				ch[b] = '0;
			end else begin
				case (kind)
					KIND_FORE: ch[b] = fw[CHAN_BITS-1:0];
					KIND_BACK: ch[b] = gw[CHAN_BITS-1:0];
					default:   ch[b] = mix[CHAN_BITS-1:0];
				endcase
			end
		end
		res.chan_zero = ch[0];
		res.chan_one  = ch[1];
		res.chan_two  = ch[2];
		res.span_end  = pix.row_end;
		return res;
	endfunction

	function automatic int field_diff(input string name, input int want, input int got);
		if (want == got) return 0;
		$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int bad;
		out_word_t due;
		if (!arst_n) begin
			regs = '0;
			regs.channel_count = RST_CHANNELS;
			regs.back_color = RST_BACK_COLOR;
			colors_due.delete();
			errors <= 0;
			words_out <= 0;
			words_left <= 0;
		end else begin
			bad = 0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MODE:         regs.mode = cfg_data[1:0];
					REG_CHANNELS:     regs.channel_count = cfg_data[1:0];
					REG_FORE_COLOR:   regs.fore_color = cfg_data[COLOR_BITS-1:0];
					REG_BACK_COLOR:   regs.back_color = cfg_data[COLOR_BITS-1:0];
					REG_DELTA_X:      regs.delta_x = cfg_data[COORD_FIELD_BITS-1:0];
					REG_DELTA_Y:      regs.delta_y = cfg_data[COORD_FIELD_BITS-1:0];
					REG_INV_SCALE:    regs.inv_scale = cfg_data[INV_BITS-1:0];
					REG_OFFSET_RATIO: regs.offset_ratio = cfg_data[RATIO_BITS-1:0];
					default:          ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (colors_due.size() == 0) begin
					$display("%0t: colour word expected none got %h", $time, out_data);
					bad++;
				end else begin
					due = colors_due.pop_front();
					bad += field_diff("chan_zero", int'(due.chan_zero),
						int'(out_data.chan_zero));
					bad += field_diff("chan_one", int'(due.chan_one),
						int'(out_data.chan_one));
					bad += field_diff("chan_two", int'(due.chan_two),
						int'(out_data.chan_two));
					bad += field_diff("span_end", int'(due.span_end),
						int'(out_data.span_end));
				end
				words_out <= words_out + 1;
			end
			if (in_valid && in_ready) begin
				colors_due.push_back(shade_pixel(in_data, regs));
			end
			errors <= errors + bad;
			words_left <= colors_due.size();
		end
	end

endmodule

`default_nettype wire

@@ tb/sv/tb_gradient_pixel_generator_top.sv @@
// testbench top of the gradient pixel generator: stimulus, flow control and verdict
`default_nettype none

module tb_gradient_pixel_generator_top;
	import gpg_pkg::*;

	// run limits and pacing
	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_CYCLES  = 20;
	localparam int HOLD_CYCLES   = 80;
	localparam int RANDOM_PHASES = 12;

	// inv_scale of 2^32 makes the q16 ratio equal to the raw sum
	localparam logic [INV_BITS-1:0] INV_UNITY = 48'h0001_0000_0000;

	// where the pixel positions of a phase come from
	typedef enum {SHAPE_LINE, SHAPE_RING, SHAPE_NOISE} shape_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid, in_ready;
	logic out_valid, out_ready;
	logic cfg_valid, cfg_ready;
	in_word_t in_data;
	out_word_t out_data;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	// checker feedback
	int errors, words_out, words_left;

	// stimulus bookkeeping
	int words_sent;
	int cycle_count;
	int holds_asked, holds_done;
	bit steady_flow;
	shape_t shape;
	int geo_dx, geo_dy, geo_r;
	in_word_t probe_pixels[$];

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	gradient_pixel_generator_top DUT (
		.clk,
		.arst_n,
		.in_valid,
		.in_ready,
		.in_data,
		.out_valid,
		.out_ready,
		.out_data,
		.cfg_valid,
		.cfg_ready,
		.cfg_index,
		.cfg_data
	);

	// watches all three channels and predicts every colour word
	gradient_pixel_generator_checker u_checker (.*);

	function automatic int rand_between(input int lo, input int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	function automatic logic signed [COORD_FIELD_BITS-1:0] clamp_coord(input int v);
		if (v > 32767) return 16'sh7FFF;
		if (v < -32768) return 16'sh8000;
		return COORD_FIELD_BITS'(v);
	endfunction

	// sender gaps: mostly none, some short, a few long
	function automatic int pick_gap();
		int roll;
		if (steady_flow) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 92) return rand_between(1, 3);
		return rand_between(8, 40);
	endfunction

	function automatic in_word_t pixel_at(input int x, input int y, input bit last);
		in_word_t pix;
		pix.pos_x = clamp_coord(x);
		pix.pos_y = clamp_coord(y);
		pix.row_end = last;
		return pix;
	endfunction

	// pixel positions follow the phase geometry, with some stray noise mixed in
	function automatic in_word_t make_pixel();
		in_word_t pix;
		int k, span;
		pix.row_end = 1'($urandom_range(0, 1));
		if (shape == SHAPE_NOISE || $urandom_range(0, 9) == 0) begin
			pix.pos_x = COORD_FIELD_BITS'($urandom);
			pix.pos_y = COORD_FIELD_BITS'($urandom);
		end else if (shape == SHAPE_LINE) begin
			// walk from before the start to beyond the end of the gradient line
			k = rand_between(-64, 191);
			span = ((geo_dx < 0) ? -geo_dx : geo_dx) / 4 + ((geo_dy < 0) ? -geo_dy : geo_dy) / 4 + 1;
			pix.pos_x = clamp_coord(geo_dx * k / 128 + rand_between(-span, span));
			pix.pos_y = clamp_coord(geo_dy * k / 128 + rand_between(-span, span));
		end else begin
			// square reaching one and a half radii either side of the start point
			span = geo_r + geo_r / 2;
			pix.pos_x = clamp_coord(rand_between(-span, span));
			pix.pos_y = clamp_coord(rand_between(-span, span));
		end
		return pix;
	endfunction

	// all colour words back, so the block holds no pixel
	task automatic wait_idle();
		while (words_out != words_sent) @(posedge clk);
	endtask

	task automatic send_pixel(input in_word_t pix);
		int gap;
		gap = pick_gap();
		in_valid <= 1'b1;
		in_data  <= pix;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		words_sent++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// one register word; bits above the register width sometimes carry junk
	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val, input int width);
		logic [CFG_DATA_BITS-1:0] junk;
		junk = CFG_DATA_BITS'({$urandom, $urandom});
		if (width < CFG_DATA_BITS && $urandom_range(0, 3) == 0) begin
			val = val | (junk << width);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// writes every register back to back, valid drops only after the last
	task automatic apply_cfg(input cfg_regs_t c);
		write_reg(REG_MODE, CFG_DATA_BITS'(c.mode), $bits(c.mode));
		write_reg(REG_CHANNELS, CFG_DATA_BITS'(c.channel_count), $bits(c.channel_count));
		write_reg(REG_FORE_COLOR, CFG_DATA_BITS'(c.fore_color), COLOR_BITS);
		write_reg(REG_BACK_COLOR, CFG_DATA_BITS'(c.back_color), COLOR_BITS);
		write_reg(REG_DELTA_X, CFG_DATA_BITS'(c.delta_x), COORD_FIELD_BITS);
		write_reg(REG_DELTA_Y, CFG_DATA_BITS'(c.delta_y), COORD_FIELD_BITS);
		write_reg(REG_INV_SCALE, CFG_DATA_BITS'(c.inv_scale), INV_BITS);
		write_reg(REG_OFFSET_RATIO, CFG_DATA_BITS'(c.offset_ratio), RATIO_BITS);
		cfg_valid <= 1'b0;
	endtask

	// sends the queued probe pixels under one register set
	task automatic run_probes(input cfg_regs_t c, input bit write_cfg);
		wait_idle();
		if (write_cfg) apply_cfg(c);
		while (probe_pixels.size() != 0) send_pixel(probe_pixels.pop_front());
		in_valid <= 1'b0;
	endtask

	task automatic directed_tests();
		cfg_regs_t c;
		// reset registers: zero inv_scale gives a zero ratio, so pure foreground
		c = '0;
		probe_pixels.push_back(pixel_at(0, 0, 1'b0));
		probe_pixels.push_back(pixel_at(32767, -32768, 1'b1));
		probe_pixels.push_back(pixel_at(-32768, 32767, 1'b0));
		run_probes(c, 1'b0);

		// linear, ratio equal to 256*pos_x: exactly one, just past one, half, below zero
		c = '{mode: MODE_LINEAR, channel_count: 2'd3, fore_color: 24'h00FF80,
			back_color: 24'hFF0040, delta_x: 16'sd256, delta_y: 16'sd0,
			inv_scale: INV_UNITY, offset_ratio: '0};
		probe_pixels.push_back(pixel_at(256, 7, 1'b0));
		probe_pixels.push_back(pixel_at(257, 0, 1'b1));
		probe_pixels.push_back(pixel_at(128, -5, 1'b0));
		probe_pixels.push_back(pixel_at(-1, 0, 1'b0));
		probe_pixels.push_back(pixel_at(0, 0, 1'b1));
		run_probes(c, 1'b1);

		// bilinear with the offset at one half: magnitude on both sides of the threshold
		c.mode = MODE_BILINEAR;
		c.offset_ratio = 18'd32768;
		probe_pixels.push_back(pixel_at(128, 0, 1'b0));
		probe_pixels.push_back(pixel_at(-128, 0, 1'b1));
		probe_pixels.push_back(pixel_at(-127, 0, 1'b0));
		probe_pixels.push_back(pixel_at(127, 0, 1'b0));
		probe_pixels.push_back(pixel_at(-300, 0, 1'b1));
		run_probes(c, 1'b1);

		// extreme deltas and inv_scale: clamp at two, negative side, two channels only
		c = '{mode: MODE_LINEAR, channel_count: 2'd2, fore_color: 24'h5A3C11,
			back_color: 24'hA5C3EE, delta_x: 16'sh8000, delta_y: 16'sh7FFF,
			inv_scale: 48'hFFFF_FFFF_FFFF, offset_ratio: '0};
		probe_pixels.push_back(pixel_at(-32768, 32767, 1'b0));
		probe_pixels.push_back(pixel_at(32767, -32768, 1'b1));
		probe_pixels.push_back(pixel_at(1, 1, 1'b0));
		probe_pixels.push_back(pixel_at(0, 0, 1'b1));
		run_probes(c, 1'b1);

		// radial, one channel, largest offset; the far corner clamps to background
		c = '{mode: MODE_RADIAL, channel_count: 2'd1, fore_color: 24'h123456,
			back_color: 24'h89ABCD, delta_x: 16'sd0, delta_y: 16'sd0,
			inv_scale: 48'h0000_0004_0000, offset_ratio: 18'h20000};
		probe_pixels.push_back(pixel_at(-32768, -32768, 1'b1));
		probe_pixels.push_back(pixel_at(0, 0, 1'b0));
		probe_pixels.push_back(pixel_at(16384, 0, 1'b0));
		run_probes(c, 1'b1);

		// solid background with no channels: all zero
		c.mode = MODE_SOLID;
		c.channel_count = 2'd0;
		probe_pixels.push_back(pixel_at(100, -100, 1'b1));
		run_probes(c, 1'b1);

		// solid background, full colour
		c.channel_count = 2'd3;
		c.back_color = 24'hC0FFEE;
		probe_pixels.push_back(pixel_at(-1, -1, 1'b0));
		probe_pixels.push_back(pixel_at(32767, 32767, 1'b1));
		run_probes(c, 1'b1);
	endtask

	// one random register set, then a burst of pixels that fit its geometry
	task automatic random_phase(input int phase_no);
		cfg_regs_t c;
		int roll, items, len2;
		roll = $urandom_range(0, 9);
		c.fore_color = COLOR_BITS'($urandom);
		c.back_color = COLOR_BITS'($urandom);
		c.channel_count = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(1, 2)) : 2'd3;
		c.offset_ratio = ($urandom_range(0, 3) == 0) ? RATIO_BITS'($urandom_range(0, 131072))
			: RATIO_BITS'($urandom_range(0, 65536));
		geo_dx = rand_between(16, 3000);
		if ($urandom_range(0, 1)) geo_dx = -geo_dx;
		geo_dy = ($urandom_range(0, 4) == 0) ? 0 : rand_between(16, 3000);
		if ($urandom_range(0, 1)) geo_dy = -geo_dy;
		geo_r = rand_between(8, 5000);
		c.delta_x = COORD_FIELD_BITS'(geo_dx);
		c.delta_y = COORD_FIELD_BITS'(geo_dy);
		if (roll < 5) begin
			// gradient line: inv_scale from the squared length
			shape = SHAPE_LINE;
			c.mode = (roll < 3) ? MODE_LINEAR : MODE_BILINEAR;
			len2 = geo_dx * geo_dx + geo_dy * geo_dy;
			c.inv_scale = INV_BITS'((longint'(1) << INV_BITS) / len2);
		end else if (roll < 8) begin
			// circle: inv_scale from the squared radius
			shape = SHAPE_RING;
			c.mode = MODE_RADIAL;
			c.inv_scale = INV_BITS'((longint'(1) << INV_BITS) / (longint'(geo_r) * geo_r));
		end else if (roll == 8) begin
			// nothing consistent: any mode, any deltas, scale of any size
			shape = SHAPE_NOISE;
			c.mode = 2'($urandom_range(0, 3));
			c.delta_x = COORD_FIELD_BITS'($urandom);
			c.delta_y = COORD_FIELD_BITS'($urandom);
			c.inv_scale = INV_BITS'({$urandom, $urandom}) >> $urandom_range(0, INV_BITS - 1);
		end else begin
			shape = SHAPE_RING;
			c.mode = MODE_SOLID;
			c.inv_scale = INV_BITS'({$urandom, $urandom});
		end

		wait_idle();
		apply_cfg(c);
		items = rand_between(35, 65);
		steady_flow = ($urandom_range(0, 4) == 0);
		// long receiver hold while the sender keeps pushing, so the pipe fills
		if (phase_no == 3 || phase_no == 8) begin
			steady_flow = 1'b1;
			holds_asked++;
		end
		for (int i = 0; i < items; i++) begin
			// sender pause until every colour word is back
			if (phase_no == 5 && i == items / 2) begin
				in_valid <= 1'b0;
				wait_idle();
			end
			send_pixel(make_pixel());
		end
		in_valid <= 1'b0;
		steady_flow = 1'b0;
	endtask

	// receiver side: random ready, long holds on request
	initial begin
		int roll;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_done != holds_asked) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end else if (steady_flow) begin
				out_ready <= 1'b1;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 70) begin
					out_ready <= 1'b1;
				end else if (roll < 95) begin
					out_ready <= 1'b0;
				end else begin
					out_ready <= 1'b0;
					repeat (rand_between(8, 40)) @(posedge clk);
				end
			end
		end
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("gradient_pixel_generator_top: mismatch");
		$finish;
	end

	// stimulus and verdict
	initial begin
		words_sent = 0;
		holds_asked = 0;
		holds_done = 0;
		steady_flow = 1'b0;
		shape = SHAPE_NOISE;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_MODE;
		cfg_data  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_tests();
		for (int p = 0; p < RANDOM_PHASES; p++) random_phase(p);

		// drain, then idle for DRAIN_CYCLES to catch anything stray
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && words_left == 0) begin
			$display("gradient_pixel_generator_top: match");
		end else begin
			$display("gradient_pixel_generator_top: mismatch");
		end
		$finish;
	end

endmodule

`default_nettype wire
